// ----- src/lpts_pkg.sv -----
`timescale 1ns / 1ps
package lpts_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int ID_W  = 10;
  localparam int MIN_W = 11;

  // Command codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // Result kinds
  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Classified request passed from front to back
  typedef struct packed {
    logic             is_drain;
    logic [ID_W-1:0]  task_id;
    logic [MIN_W-1:0] start_minute;
    logic [MIN_W-1:0] duration;
  } req_t;

endpackage

// ----- src/lpts_front.sv -----
`timescale 1ns / 1ps
module lpts_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic [lpts_pkg::ID_W-1:0]  task_id,
  input  logic [lpts_pkg::MIN_W-1:0] start_minute,
  input  logic [lpts_pkg::MIN_W-1:0] duration,
  output logic                     q_valid,
  output lpts_pkg::req_t           q_req,
  input  logic                     q_take
);
  import lpts_pkg::*;

  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  req_t       req_in;

  // Classify the incoming request
  always_comb begin
    req_in.is_drain     = (cmd == CMD_DRAIN);
    req_in.task_id      = task_id;
    req_in.start_minute = start_minute;
    req_in.duration     = duration;
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_req    = slot[rd_ptr];

  // Hold requests in a two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= req_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/lpts_back.sv -----
`timescale 1ns / 1ps
module lpts_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  lpts_pkg::req_t            q_req,
  output logic                      q_take,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lpts_pkg::ID_W-1:0] done_id,
  output logic                      kind,
  output logic                      last
);
  import lpts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Stack memories
  logic [ID_W-1:0]  ids  [STACK_DEPTH];
  logic [MIN_W-1:0] rems [STACK_DEPTH];

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [MIN_W-1:0] now, now_next;
  req_t             req, req_next;
  logic             pend_valid, pend_valid_next;
  logic [ID_W-1:0]  pend_id, pend_id_next;

  logic [ID_W-1:0]  rd_id;
  logic [MIN_W-1:0] rd_rem;
  logic             mem_re;
  logic             id_we;
  logic             rem_we;
  logic [PTR_W-1:0] mem_wa;
  logic [MIN_W-1:0] rem_wd;

  logic             out_load;
  logic [ID_W-1:0]  out_id;
  logic             out_kind;
  logic             out_last;
  logic             out_free;

  logic [CNT_W-1:0] count_m1;
  logic [PTR_W-1:0] top_ptr;
  logic [MIN_W-1:0] avail;
  logic [MIN_W-1:0] now_plus;
  logic             fits;
  logic             full;

  assign out_free = !out_valid || !out_stall;
  assign count_m1 = count - CNT_W'(1);
  assign top_ptr  = count_m1[PTR_W-1:0];
  assign avail    = req.start_minute - now;
  assign now_plus = now + rd_rem;
  assign fits     = (rd_rem <= avail);
  assign full     = (count == CNT_W'(STACK_DEPTH));

  // Sequence pops, partial updates and pushes
  always_comb begin
    state_next      = state;
    count_next      = count;
    now_next        = now;
    req_next        = req;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    q_take          = 1'b0;
    mem_re          = 1'b0;
    id_we           = 1'b0;
    rem_we          = 1'b0;
    mem_wa          = top_ptr;
    rem_wd          = rd_rem - avail;
    out_load        = 1'b0;
    out_id          = pend_id;
    out_kind        = KIND_DONE;
    out_last        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_take   = 1'b1;
          req_next = q_req;
          if (q_req.is_drain) begin
            if (count == '0) begin
              now_next = '0;
            end else begin
              state_next = ST_RD;
            end
          end else if (count != '0 && now < q_req.start_minute) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_RD: begin
        mem_re     = 1'b1;
        state_next = ST_EV;
      end
      ST_EV: begin
        if (req.is_drain) begin
          // Report the top task and pop it
          if (out_free) begin
            out_load   = 1'b1;
            out_id     = rd_id;
            out_last   = (count_m1 == '0);
            count_next = count_m1;
            if (count_m1 == '0) begin
              now_next   = '0;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_RD;
            end
          end
        end else if (fits) begin
          // Top task completes: flush any held result, hold this one
          if (!pend_valid || out_free) begin
            out_load        = pend_valid;
            pend_valid_next = 1'b1;
            pend_id_next    = rd_id;
            count_next      = count_m1;
            now_next        = now_plus;
            if (count_m1 != '0 && now_plus < req.start_minute) begin
              state_next = ST_RD;
            end else begin
              state_next = ST_FIN;
            end
          end
        end else begin
          // Top task runs out of time: keep what is left
          rem_we     = 1'b1;
          now_next   = req.start_minute;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (now < req.start_minute) begin
          now_next = req.start_minute;
        end
        if (full) begin
          if (pend_valid) begin
            if (out_free) begin
              out_load        = 1'b1;
              pend_valid_next = 1'b0;
            end
          end else if (out_free) begin
            out_load   = 1'b1;
            out_id     = req.task_id;
            out_kind   = KIND_REJECT;
            out_last   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!pend_valid || out_free) begin
          // Push the new task as the running one
          id_we           = 1'b1;
          rem_we          = 1'b1;
          mem_wa          = count[PTR_W-1:0];
          rem_wd          = req.duration;
          count_next      = count + CNT_W'(1);
          out_load        = pend_valid;
          out_last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Stack memory access
  always_ff @(posedge clk) begin
    if (id_we) begin
      ids[mem_wa] <= req.task_id;
    end
    if (rem_we) begin
      rems[mem_wa] <= rem_wd;
    end
    if (mem_re) begin
      rd_id  <= ids[top_ptr];
      rd_rem <= rems[top_ptr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      now        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      now        <= now_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Request and held result payload
  always_ff @(posedge clk) begin
    req     <= req_next;
    pend_id <= pend_id_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      done_id <= out_id;
      kind    <= out_kind;
      last    <= out_last;
    end
  end

endmodule

// ----- src/lifo_preemptive_task_scheduler.sv -----
`timescale 1ns / 1ps
// LIFO preemptive task scheduler.
// Input channel (in_valid / in_stall): one request per handshake, either a
// task arrival (cmd = 0, with task_id, start_minute, duration, in start order)
// or a drain (cmd = 1). Requests enter a two-entry queue; in_stall rises only
// when that queue is full.
// Output channel (out_valid / out_stall): one result per handshake, done_id
// and kind (finished or rejected), with last set on the final result of a
// request. A request with no result (arrival pushed without completions,
// drain of an empty stack) produces nothing.
// Sequencing: an accepted request is registered in the queue before the
// sequencer takes it. An arrival that pops nothing goes idle, then finish;
// each paused task examined adds a memory read state, then an evaluate state.
// A drain takes idle, then read and evaluate per task (one stack read port).
// A completed task's result is held until the next step shows if it is last.
// out_stall freezes the output register; the sequencer waits while a new
// result has nowhere to go, and the queue keeps taking requests until full.
// Reset (rst, synchronous) empties the stack, sets the clock to minute zero
// and clears both queue and output; no clearing pass is needed.
module lifo_preemptive_task_scheduler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [lpts_pkg::ID_W-1:0]  task_id,
  input  logic [lpts_pkg::MIN_W-1:0] start_minute,
  input  logic [lpts_pkg::MIN_W-1:0] duration,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lpts_pkg::ID_W-1:0]  done_id,
  output logic                       kind,
  output logic                       last
);
  import lpts_pkg::*;

  logic q_valid;
  req_t q_req;
  logic q_take;

  lpts_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .task_id      (task_id),
    .start_minute (start_minute),
    .duration     (duration),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_take       (q_take)
  );

  lpts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .done_id   (done_id),
    .kind      (kind),
    .last      (last)
  );

endmodule

// ----- bench/lifo_preemptive_task_scheduler_tb.sv -----
`timescale 1ns / 1ps
module lifo_preemptive_task_scheduler_tb;
  import lpts_pkg::*;

  localparam int RANDOM_ITEMS    = 250;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 120;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 100;

  typedef struct packed {
    logic             cmd;
    logic [ID_W-1:0]  id;
    logic [MIN_W-1:0] start;
    logic [MIN_W-1:0] dur;
    logic             settle;
  } sched_req_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            kind;
    logic            last;
  } task_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HALF} stall_mode_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = CMD_ARRIVE;
  logic [ID_W-1:0]      task_id = '0;
  logic [MIN_W-1:0]     start_minute = '0;
  logic [MIN_W-1:0]     duration = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ID_W-1:0]      done_id;
  logic                 kind;
  logic                 last;

  // Requests waiting to be offered, and results the schedule predicts
  sched_req_t   req_queue[$];
  task_result_t due_results[$];

  // Predicted scheduler state
  logic [ID_W-1:0]  paused_ids [STACK_DEPTH];
  logic [MIN_W-1:0] paused_left[STACK_DEPTH];
  int               paused_fill = 0;
  logic [MIN_W-1:0] clock_minute = '0;
  task_result_t     held_result;
  bit               held_valid = 1'b0;

  // Bookkeeping
  int          mismatches = 0;
  int          exp_count = 0;
  int          got_count = 0;
  int          reqs_taken = 0;
  int          gap_left = 0;
  int          burst_left = 1;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  sched_req_t  live_req;

  lifo_preemptive_task_scheduler i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .task_id      (task_id),
    .start_minute (start_minute),
    .duration     (duration),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .done_id      (done_id),
    .kind         (kind),
    .last         (last)
  );

  always #1 clk = ~clk;

  // Hold each result back until the next one shows it was not the last
  function automatic void note_result(input logic [ID_W-1:0] id, input logic k);
    if (held_valid) due_results = {due_results, held_result};
    held_result.id   = id;
    held_result.kind = k;
    held_result.last = 1'b0;
    held_valid       = 1'b1;
  endfunction

  // Advance the predicted schedule by one request; return the number of results
  function automatic int schedule_request(input sched_req_t rq);
    int n;
    int avail;
    int top;
    n = 0;
    held_valid = 1'b0;
    if (rq.cmd == CMD_DRAIN) begin
      while (paused_fill > 0) begin
        paused_fill--;
        note_result(paused_ids[paused_fill], KIND_DONE);
        n++;
      end
      clock_minute = '0;
    end else begin
      // Spend the time up to the new start on the paused tasks, top first
      while (paused_fill > 0 && clock_minute < rq.start) begin
        top   = paused_fill - 1;
        avail = int'(rq.start) - int'(clock_minute);
        if (int'(paused_left[top]) <= avail) begin
          clock_minute = clock_minute + paused_left[top];
          paused_fill  = top;
          note_result(paused_ids[top], KIND_DONE);
          n++;
        end else begin
          paused_left[top] = paused_left[top] - MIN_W'(avail);
          clock_minute     = rq.start;
        end
      end
      if (clock_minute < rq.start) clock_minute = rq.start;
      if (paused_fill >= STACK_DEPTH) begin
        note_result(rq.id, KIND_REJECT);
        n++;
      end else begin
        paused_ids[paused_fill]  = rq.id;
        paused_left[paused_fill] = rq.dur;
        paused_fill++;
      end
    end
    if (held_valid) begin
      held_result.last = 1'b1;
      due_results = {due_results, held_result};
      held_valid = 1'b0;
    end
    return n;
  endfunction

  task automatic add_arrival(input int id, input int start, input int dur, input bit settle);
    sched_req_t rq;
    rq.cmd    = CMD_ARRIVE;
    rq.id     = ID_W'(id);
    rq.start  = MIN_W'(start);
    rq.dur    = MIN_W'(dur);
    rq.settle = settle;
    req_queue = {req_queue, rq};
  endtask

  // Drain payload fields carry random content; the block ignores them
  task automatic add_drain(input bit settle);
    sched_req_t rq;
    rq.cmd    = CMD_DRAIN;
    rq.id     = ID_W'($urandom_range(0, 1023));
    rq.start  = MIN_W'($urandom_range(0, 2047));
    rq.dur    = MIN_W'($urandom_range(0, 2047));
    rq.settle = settle;
    req_queue = {req_queue, rq};
  endtask

  // Request driver: bursts of requests with random gaps in between
  always @(posedge clk) begin : request_driver
    logic offer;
    if (!rst) begin
      offer = in_valid;
      if (exp_count != got_count) quiet_cycles = 0;
      else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
      if (in_valid && !in_stall) begin
        exp_count += schedule_request(live_req);
        reqs_taken <= reqs_taken + 1;
        quiet_cycles = 0;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_queue.size() > 0 &&
                     (!req_queue[0].settle || quiet_cycles >= SETTLE_CYCLES)) begin
          live_req = req_queue.pop_front();
          cmd          <= live_req.cmd;
          task_id      <= live_req.id;
          start_minute <= live_req.start;
          duration     <= live_req.dur;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20)
                                                     : $urandom_range(0, 2);
          end
        end
      end
      in_valid <= offer;
    end
  end

  // Result monitor: check each result against the oldest prediction
  always @(posedge clk) begin : result_monitor
    task_result_t want;
    logic         nxt_stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: done_id=%0d kind=%0d last=%0d",
                   $time, done_id, kind, last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (done_id !== want.id) begin
            $display("%0t: done_id mismatch: expected %0d, actual %0d",
                     $time, want.id, done_id);
            mismatches++;
          end
          if (kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, kind);
            mismatches++;
          end
          if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0d, actual %0d",
                     $time, want.last, last);
            mismatches++;
          end
          got_count <= got_count + 1;
        end
      end
      // Hold off once for a long stretch, otherwise stall on a random pattern
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (!hold_done && reqs_taken >= HOLD_OFF_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        nxt_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(5, 60);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE:  nxt_stall = 1'b0;
          STALL_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
          default:     nxt_stall = ($urandom_range(0, 1) == 1);
        endcase
      end
      out_stall <= nxt_stall;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int n;
    int t;
    int dur;
    int pick;
    int target;
    bit crowded_first;

    // Directed: empty drain, zero and full-width fields, partial runs, late jumps
    add_drain(1'b0);
    add_arrival(0, 0, 1, 1'b0);
    add_arrival(1023, 0, 0, 1'b0);
    add_arrival(5, 10, 2047, 1'b0);
    add_arrival(6, 5, 3, 1'b0);
    add_arrival(7, 1439, 1440, 1'b0);
    add_arrival(8, 2047, 100, 1'b0);
    add_arrival(9, 2047, 1, 1'b0);
    add_drain(1'b0);
    add_arrival(512, 0, 5, 1'b0);
    add_arrival(513, 3, 1, 1'b0);
    add_arrival(514, 100, 1, 1'b0);
    add_arrival(515, 101, 0, 1'b0);
    add_arrival(516, 101, 2, 1'b0);
    add_drain(1'b1);
    add_drain(1'b0);
    add_arrival(341, 2047, 0, 1'b1);
    add_arrival(682, 2047, 2047, 1'b0);
    add_drain(1'b0);

    // Random: mostly well-formed days, some crowded days, some noise
    target        = req_queue.size() + RANDOM_ITEMS;
    crowded_first = 1'b1;
    while (req_queue.size() < target) begin
      pick = $urandom_range(0, 99);
      if (crowded_first || pick < 12) begin
        // Fill the stack past its depth to force rejections
        crowded_first = 1'b0;
        n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
        t = $urandom_range(0, 100);
        repeat (n) begin
          add_arrival($urandom_range(0, 1023), t, $urandom_range(600, 1440), 1'b0);
          t += $urandom_range(0, 2);
        end
        add_drain($urandom_range(0, 4) == 0);
      end else if (pick < 85) begin
        n = $urandom_range(1, 12);
        t = $urandom_range(0, 60);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0:       dur = 1440;
            1:       dur = 1;
            default: dur = $urandom_range(1, 300);
          endcase
          add_arrival($urandom_range(0, 1023), t, dur, 1'b0);
          if ($urandom_range(0, 9) == 0) t -= $urandom_range(0, 50);
          else t += $urandom_range(0, 150);
          if (t < 0) t = 0;
          if (t > 2047) t = 2047;
        end
        if ($urandom_range(0, 6) != 0) add_drain($urandom_range(0, 9) == 0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) add_drain(1'b0);
          else add_arrival($urandom_range(0, 1023), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), 1'b0);
        end
      end
    end
    add_drain(1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last request and its results, then let the block settle
    do @(negedge clk);
    while (req_queue.size() != 0 || in_valid || exp_count != got_count);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, due_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung block
  initial begin : watchdog
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
